// ===== rtl/smst_pkg.sv =====
// ----------------------------------------------------------------------------
// smst_pkg
// shared types and constants of the segment map sector translator
// ----------------------------------------------------------------------------
package smst_pkg;

	localparam int WORD_W      = 16;
	localparam int INDEX_W     = 6;
	localparam int LSECT_W     = 15;
	localparam int PSECT_W     = 13;
	localparam int COUNT_W     = 16;
	localparam int END_BIT     = 15;
	localparam int SIZE_LSB    = 10;
	localparam int SIZE_W      = 5;
	localparam int CLUSTER_W   = 10;
	localparam int CLUS_SHIFT  = 2;
	localparam int MAX_EXT_CLU = 32;

	localparam logic KIND_LOAD      = 1'b0;
	localparam logic KIND_TRANSLATE = 1'b1;

	typedef struct packed {
		logic start;
		logic step;
		logic load;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic word_end;
		logic last;
	} dp_sts_t;

endpackage

// ===== rtl/smst_ctrl.sv =====
// ----------------------------------------------------------------------------
// smst_ctrl
// controller: sequences loads, the descriptor walk and result hand-off
// ----------------------------------------------------------------------------
module smst_ctrl import smst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    kind,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PRIME = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		cmd.start = 1'b0;
		cmd.step  = 1'b0;
		cmd.load  = 1'b0;
		cmd.emit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_TRANSLATE) begin
						cmd.start = 1'b1;
						state_d   = ST_PRIME;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_PRIME: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (sts.word_end || sts.last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/smst_dpath.sv =====
// ----------------------------------------------------------------------------
// smst_dpath
// datapath: descriptor memory, walk accumulators and result registers
// ----------------------------------------------------------------------------
module smst_dpath import smst_pkg::*; #(
	parameter int NUM_WORDS = 64
) (
	input  logic                 clk,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	input  logic [INDEX_W-1:0]   word_index,
	input  logic [WORD_W-1:0]    word_value,
	input  logic [LSECT_W-1:0]   logical_sector,
	output logic [PSECT_W-1:0]   physical_sector,
	output logic                 mapped,
	output logic [COUNT_W-1:0]   file_sectors
);

	localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int IW = AW + INDEX_W;
	localparam int CW = $clog2(NUM_WORDS * MAX_EXT_CLU + 1);

	logic [WORD_W-1:0]  mem [NUM_WORDS];
	logic [WORD_W-1:0]  rdata_q;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      idx_q;
	logic [IW-1:0]      widx;
	logic [LSECT_W-1:0] rem_q;
	logic [PSECT_W-1:0] phys_q;
	logic               hit_q;
	logic               end_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [CW-1:0]      clus_q;
	logic [SIZE_W:0]    size;
	logic [SIZE_W+CLUS_SHIFT:0] len;
	logic [PSECT_W-1:0] phys_hit;
	logic [PSECT_W-1:0] phys_q_out;
	logic               mapped_q;
	logic [COUNT_W-1:0] fsect_q;

	assign widx  = IW'(word_index);
	assign raddr = cmd.step ? (idx_q + AW'(1)) : idx_q;

	assign size     = {1'b0, rdata_q[SIZE_LSB +: SIZE_W]} + (SIZE_W+1)'(1);
	assign len      = {size, {CLUS_SHIFT{1'b0}}};
	assign phys_hit = PSECT_W'({rdata_q[CLUSTER_W-1:0], {CLUS_SHIFT{1'b0}}})
		+ rem_q[PSECT_W-1:0];

	assign sts.word_end = rdata_q[END_BIT];
	assign sts.last     = (idx_q == AW'(NUM_WORDS - 1));

	// descriptor memory
	always_ff @(posedge clk) begin
		if (cmd.load && (widx < IW'(NUM_WORDS))) begin
			mem[widx[AW-1:0]] <= word_value;
		end
		rdata_q <= mem[raddr];
	end

	// walk state
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			idx_q  <= '0;
			rem_q  <= logical_sector;
			phys_q <= '0;
			hit_q  <= 1'b0;
			end_q  <= 1'b0;
			clus_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + AW'(1);
			if (rdata_q[END_BIT]) begin
				cnt_q <= {1'b0, rdata_q[END_BIT-1:0]} + COUNT_W'(1);
				end_q <= 1'b1;
			end else begin
				clus_q <= clus_q + CW'(size);
				if (!hit_q) begin
					if (rem_q < LSECT_W'(len)) begin
						phys_q <= phys_hit;
						hit_q  <= 1'b1;
					end else begin
						rem_q <= rem_q - LSECT_W'(len);
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			phys_q_out <= phys_q;
			mapped_q   <= hit_q;
			fsect_q    <= end_q ? cnt_q : COUNT_W'({clus_q, {CLUS_SHIFT{1'b0}}});
		end
	end

	assign physical_sector = phys_q_out;
	assign mapped          = mapped_q;
	assign file_sectors    = fsect_q;

endmodule

// ===== rtl/segment_map_sector_translate_unit.sv =====
// ----------------------------------------------------------------------------
// segment_map_sector_translate_unit
// translates a logical file sector to a disk sector through a segment map
// ----------------------------------------------------------------------------
// A load transaction (kind 0) writes one descriptor word; an index at or beyond
// NUM_WORDS is dropped. A translate transaction (kind 1) walks the descriptor
// words from word 0, one per cycle out of the single-read-port descriptor
// memory, stopping at the end word or after the last word, so it walks 1 to
// NUM_WORDS words: a prime state reads word 0, the walk state takes each word in
// turn, and the final state hands the result to the output register once that
// is free of an unread result. One translation is in flight at a time; loads are
// taken while a finished result waits in the output register. The memory has no
// reset: a translation must only reach words that were loaded since reset.
// ----------------------------------------------------------------------------
module segment_map_sector_translate_unit import smst_pkg::*; #(
	parameter int NUM_WORDS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [INDEX_W-1:0] word_index,
	input  logic [WORD_W-1:0]  word_value,
	input  logic [LSECT_W-1:0] logical_sector,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PSECT_W-1:0] physical_sector,
	output logic               mapped,
	output logic [COUNT_W-1:0] file_sectors
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	smst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	smst_dpath #(
		.NUM_WORDS (NUM_WORDS)
	) u_dpath (
		.clk             (clk),
		.cmd             (cmd),
		.sts             (sts),
		.word_index      (word_index),
		.word_value      (word_value),
		.logical_sector  (logical_sector),
		.physical_sector (physical_sector),
		.mapped          (mapped),
		.file_sectors    (file_sectors)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.step, cmd.load, cmd.emit}))
		else $error("datapath commands overlap");

	a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !in_ready)
		else $error("input taken during walk");

	a_start_primes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !cmd.step && !in_ready)
		else $error("walk started without memory prime cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("pending result overwritten");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("result emitted without out_valid");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the segment map sector translator
// ----------------------------------------------------------------------------
// Starts with a table of directed transactions: all-ones and all-zero fields,
// an end word first in the list, extents that end right at a sector boundary
// and a list whose end word comes before any covering extent. Some rows carry
// a hand-typed expected result. Random segment lists follow: an end word then
// extents written in shuffled order, lists with no end word at all, broken lists
// and stray loads; each list is followed by lookups inside it, at extent edges
// and at random. A local copy of the descriptor list predicts every lookup with
// no hand-typed result, and no lookup is sent that would walk into a word not
// written since reset. The sender works in bursts and the receiver stalls in
// modes of its own. A watchdog ends the run when nothing moves for too long.
// ----------------------------------------------------------------------------
module tb_top import smst_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_WORDS   = 64;
	localparam int ITEM_TARGET = 1750;
	localparam int STALL_LIMIT = 4000;
	localparam int PLAN_ROWS   = 23;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [PSECT_W-1:0] phys;
		logic               hit;
		logic [COUNT_W-1:0] sectors;
	} lookup_t;

	typedef struct packed {
		logic               op;
		logic [INDEX_W-1:0] idx;
		logic [WORD_W-1:0]  value;
		logic [LSECT_W-1:0] lsect;
		logic               typed;
		lookup_t            want;
	} plan_row_t;

	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{KIND_LOAD,      6'd0,  16'hFFFF, 15'h0000, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_TRANSLATE, 6'd0,  16'h0000, 15'h0000, 1'b1, '{13'd0, 1'b0, 16'h8000}},
		'{KIND_TRANSLATE, 6'd63, 16'hFFFF, 15'h7FFF, 1'b1, '{13'd0, 1'b0, 16'h8000}},
		'{KIND_LOAD,      6'd0,  16'h8000, 15'h7FFF, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_TRANSLATE, 6'd0,  16'h0000, 15'h0000, 1'b1, '{13'd0, 1'b0, 16'd1}},
		'{KIND_LOAD,      6'd0,  16'h0000, 15'h0000, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_LOAD,      6'd1,  16'h8003, 15'h0000, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_TRANSLATE, 6'd0,  16'h0000, 15'd0,    1'b1, '{13'd0, 1'b1, 16'd4}},
		'{KIND_TRANSLATE, 6'd0,  16'h0000, 15'd3,    1'b1, '{13'd3, 1'b1, 16'd4}},
		'{KIND_TRANSLATE, 6'd0,  16'h0000, 15'd4,    1'b1, '{13'd0, 1'b0, 16'd4}},
		'{KIND_LOAD,      6'd0,  16'h7FFF, 15'h0000, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_TRANSLATE, 6'd0,  16'h0000, 15'd127,  1'b1, '{13'h107B, 1'b1, 16'd4}},
		'{KIND_TRANSLATE, 6'd0,  16'h0000, 15'd128,  1'b1, '{13'd0, 1'b0, 16'd4}},
		'{KIND_LOAD,      6'd2,  16'h8000, 15'h0000, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_LOAD,      6'd1,  16'h03FF, 15'h0000, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_TRANSLATE, 6'd0,  16'h0000, 15'd130,  1'b1, '{13'h0FFE, 1'b1, 16'd1}},
		'{KIND_TRANSLATE, 6'd0,  16'h0000, 15'd132,  1'b1, '{13'd0, 1'b0, 16'd1}},
		'{KIND_LOAD,      6'd63, 16'hAAAA, 15'h0000, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_LOAD,      6'd42, 16'h5555, 15'h0000, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_LOAD,      6'd21, 16'h2A2A, 15'h0000, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_LOAD,      6'd3,  16'h83FF, 15'h0000, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_TRANSLATE, 6'd21, 16'h5555, 15'h2AAA, 1'b0, '{13'd0, 1'b0, 16'd0}},
		'{KIND_TRANSLATE, 6'd42, 16'hAAAA, 15'h5555, 1'b0, '{13'd0, 1'b0, 16'd0}}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               kind;
	logic [INDEX_W-1:0] word_index;
	logic [WORD_W-1:0]  word_value;
	logic [LSECT_W-1:0] logical_sector;
	logic               out_valid;
	logic               out_ready;
	logic [PSECT_W-1:0] physical_sector;
	logic               mapped;
	logic [COUNT_W-1:0] file_sectors;

	logic [WORD_W-1:0] seg_words [NUM_WORDS];
	bit                written [NUM_WORDS];
	lookup_t           lookups_due [$];
	int                mismatches;
	int                items_sent;
	int                burst_left;
	int                quiet_cycles;
	int                ready_mode;
	int                mode_left;

	segment_map_sector_translate_unit #(
		.NUM_WORDS(NUM_WORDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.word_index(word_index),
		.word_value(word_value),
		.logical_sector(logical_sector),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.physical_sector(physical_sector),
		.mapped(mapped),
		.file_sectors(file_sectors)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic lookup_t walk_segment_map(input logic [LSECT_W-1:0] lsect);
		lookup_t     r;
		int unsigned left;
		int unsigned clusters;
		int unsigned size;
		int unsigned count;
		int unsigned start;
		bit          ended;
		bit          searching;
		r = '0;
		left = lsect;
		clusters = 0;
		count = 0;
		ended = 1'b0;
		searching = 1'b1;
		for (int i = 0; i < NUM_WORDS; i++) begin
			if (seg_words[i][END_BIT]) begin
				count = seg_words[i][END_BIT-1:0];
				count = count + 1;
				ended = 1'b1;
				break;
			end
			size = seg_words[i][SIZE_LSB +: SIZE_W];
			size = size + 1;
			clusters = clusters + size;
			if (searching) begin
				if (left < (size << CLUS_SHIFT)) begin
					start = seg_words[i][CLUSTER_W-1:0];
					r.phys = PSECT_W'((start << CLUS_SHIFT) + left);
					r.hit = 1'b1;
					searching = 1'b0;
				end else begin
					left = left - (size << CLUS_SHIFT);
				end
			end
		end
		if (!ended)
			count = clusters << CLUS_SHIFT;
		r.sectors = COUNT_W'(count);
		return r;
	endfunction

	// a lookup may only walk words written since reset
	function automatic bit translate_is_safe();
		for (int i = 0; i < NUM_WORDS; i++) begin
			if (!written[i])
				return 1'b0;
			if (seg_words[i][END_BIT])
				return 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic int extent_sectors(input int upto);
		int sum;
		sum = 0;
		for (int i = 0; i < upto; i++)
			sum = sum + ((int'(seg_words[i][SIZE_LSB +: SIZE_W]) + 1) << CLUS_SHIFT);
		return sum;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
		input int unsigned got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
	endtask

	task automatic push_item(input logic op, input logic [INDEX_W-1:0] idx,
		input logic [WORD_W-1:0] value, input logic [LSECT_W-1:0] lsect,
		input bit typed, input lookup_t want);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= op;
		word_index <= idx;
		word_value <= value;
		logical_sector <= lsect;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (op == KIND_TRANSLATE) begin
			lookups_due.push_back(typed ? want : walk_segment_map(lsect));
		end else if (idx < NUM_WORDS) begin
			seg_words[idx] = value;
			written[idx] = 1'b1;
		end
	endtask

	task automatic push_lookup(input logic [LSECT_W-1:0] lsect);
		if (translate_is_safe())
			push_item(KIND_TRANSLATE, INDEX_W'($urandom), WORD_W'($urandom), lsect, 1'b0, '0);
	endtask

	task automatic wait_for_lookups();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (lookups_due.size() != 0) @(posedge clk);
	endtask

	// extents plus an end word, or a full list of extents with no end word
	task automatic run_segment_list(input bit no_end);
		int                n;
		int                total;
		int                pick;
		int                cum;
		int                j;
		int                tmp;
		int                order [NUM_WORDS];
		logic [WORD_W-1:0] w;
		logic [LSECT_W-1:0] ls;
		if (no_end)
			n = NUM_WORDS;
		else if ($urandom_range(0, 7) == 0)
			n = $urandom_range(9, NUM_WORDS - 1);
		else
			n = $urandom_range(0, 8);
		for (int i = 0; i < n; i++)
			order[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		if (!no_end)
			push_item(KIND_LOAD, INDEX_W'(n), WORD_W'($urandom) | 16'h8000,
				LSECT_W'($urandom), 1'b0, '0);
		for (int i = 0; i < n; i++) begin
			w = WORD_W'($urandom) & 16'h7FFF;
			if ($urandom_range(0, 1) == 0)
				w[SIZE_LSB +: SIZE_W] = SIZE_W'($urandom_range(0, 3));
			push_item(KIND_LOAD, INDEX_W'(order[i]), w, LSECT_W'($urandom), 1'b0, '0);
		end
		if (n + 1 < NUM_WORDS && $urandom_range(0, 3) == 0)
			push_item(KIND_LOAD, INDEX_W'($urandom_range(n + 1, NUM_WORDS - 1)),
				WORD_W'($urandom), LSECT_W'($urandom), 1'b0, '0);
		total = extent_sectors(n);
		repeat ($urandom_range(1, 8)) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				ls = (total > 0) ? LSECT_W'($urandom_range(0, total - 1)) : LSECT_W'($urandom);
			end else if (pick < 8) begin
				cum = extent_sectors($urandom_range(0, n));
				if (cum > 0)
					cum = cum - $urandom_range(0, 1);
				ls = LSECT_W'(cum);
			end else begin
				ls = LSECT_W'($urandom);
			end
			push_lookup(ls);
		end
		// broken list: the end word turns into an extent
		if (!no_end && $urandom_range(0, 5) == 0) begin
			push_item(KIND_LOAD, INDEX_W'(n), WORD_W'($urandom) & 16'h7FFF,
				LSECT_W'($urandom), 1'b0, '0);
			push_lookup(LSECT_W'($urandom_range(0, total + 200)));
		end
	endtask

	task automatic run_noise();
		logic [INDEX_W-1:0] idx;
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 1) == 0) begin
				idx = ($urandom_range(0, 1) == 0) ? INDEX_W'($urandom_range(0, 15))
					: INDEX_W'($urandom);
				push_item(KIND_LOAD, idx, WORD_W'($urandom), LSECT_W'($urandom), 1'b0, '0);
			end else begin
				push_lookup(LSECT_W'($urandom));
			end
		end
	endtask

	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= $urandom_range(0, 2);
			mode_left <= $urandom_range(20, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	always @(posedge clk) begin : check_results
		lookup_t want;
		if (arst_n && out_valid && out_ready) begin
			if (lookups_due.size() == 0) begin
				report_mismatch("transaction with none due", 0, 1);
			end else begin
				want = lookups_due.pop_front();
				if (physical_sector !== want.phys)
					report_mismatch("physical_sector", want.phys, physical_sector);
				if (mapped !== want.hit)
					report_mismatch("mapped", want.hit, mapped);
				if (file_sectors !== want.sectors)
					report_mismatch("file_sectors", want.sectors, file_sectors);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_LOAD;
		word_index = '0;
		word_value = '0;
		logical_sector = '0;
		out_ready = 1'b0;
		ready_mode = 0;
		mode_left = 0;
		quiet_cycles = 0;
		mismatches = 0;
		items_sent = 0;
		burst_left = 0;
		for (int i = 0; i < NUM_WORDS; i++) begin
			seg_words[i] = '0;
			written[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < PLAN_ROWS; r++)
			push_item(PLAN[r].op, PLAN[r].idx, PLAN[r].value, PLAN[r].lsect,
				PLAN[r].typed, PLAN[r].want);
		wait_for_lookups();

		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 99)) inside
				[0:71]: run_segment_list(1'b0);
				[72:74]: run_segment_list(1'b1);
				default: run_noise();
			endcase
			if ($urandom_range(0, 29) == 0)
				wait_for_lookups();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (lookups_due.size() != 0) @(posedge clk);
		repeat (NUM_WORDS + 8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== segment_map_sector_translate_unit.f =====
rtl/smst_pkg.sv
rtl/smst_ctrl.sv
rtl/smst_dpath.sv
rtl/segment_map_sector_translate_unit.sv
verif/tb_top.sv
